/* rtl/fastq_record_parser_macros.svh */
// ----------------------------------------------------------------------------
// FASTQ record parser assertion macros
// Same-cycle and next-cycle concurrent implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FASTQ_RECORD_PARSER_MACROS_SVH
`define FASTQ_RECORD_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define FQP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define FQP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/fqp_pkg.sv */
// ----------------------------------------------------------------------------
// fqp_pkg
// Types, codes and character checks shared by the FASTQ record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fqp_pkg;

  localparam int COUNT_BITS_DEF = 32;

  // Characters of interest
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] Q_HIGH  = 8'd126;
  localparam logic [7:0] Q_LOW_STD     = 8'd33;
  localparam logic [7:0] Q_LOW_SOLEXA  = 8'd59;
  localparam logic [7:0] Q_LOW_ILLUMINA = 8'd64;

  // Register indexes
  localparam logic [1:0] REG_SEQ_CLASSES = 2'd0;
  localparam logic [1:0] REG_QUAL_ENC    = 2'd1;
  localparam logic [1:0] REG_INTERLEAVE  = 2'd2;
  localparam logic [1:0] REG_FIRST_MATE  = 2'd3;

  // Quality encodings
  localparam logic [1:0] ENC_SOLEXA   = 2'd2;
  localparam logic [1:0] ENC_ILLUMINA = 2'd3;

  // Base class enable bits
  localparam int CLS_DNA   = 0;
  localparam int CLS_RNA   = 1;
  localparam int CLS_AMBIG = 2;
  localparam int CLS_MASK  = 3;
  localparam int CLS_LOWER = 4;
  localparam int CLS_UPPER = 5;

  typedef enum logic [2:0] {
    EV_REC_START  = 3'd0,
    EV_FIELD_BYTE = 3'd1,
    EV_FIELD_END  = 3'd2,
    EV_REC_END    = 3'd3,
    EV_ERROR      = 3'd4,
    EV_COMPLETE   = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    FK_HEADER1 = 2'd0,
    FK_SEQ     = 2'd1,
    FK_HEADER2 = 2'd2,
    FK_QUAL    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NO_HEADER  = 3'd1,
    ERR_BAD_BASE   = 3'd2,
    ERR_BAD_QUAL   = 3'd3,
    ERR_INCOMPLETE = 3'd4
  } err_t;

  typedef enum logic [6:0] {
    PH_START = 7'b0000001,
    PH_HEAD1 = 7'b0000010,
    PH_SEQ   = 7'b0000100,
    PH_SEQNL = 7'b0001000,
    PH_HEAD2 = 7'b0010000,
    PH_QUAL  = 7'b0100000,
    PH_HALT  = 7'b1000000
  } phase_t;

  // One buffered result without the per-item line and mate fields
  typedef struct packed {
    event_t      ev;
    kind_t       kind;
    logic [7:0]  data;
    err_t        err;
  } res_t;

  // Check a sequence byte against the enabled base classes
  function automatic logic base_ok(input logic [7:0] c, input logic [5:0] cls);
    logic [7:0] u;
    logic       case_ok;
    logic       hit;
    begin
      u       = c;
      case_ok = 1'b0;
      hit     = 1'b0;
      if (c >= 8'h61 && c <= 8'h7A) begin
        case_ok = cls[CLS_LOWER];
        u       = c - 8'd32;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
        case_ok = cls[CLS_UPPER];
      end
      // A C G T N
      if (cls[CLS_DNA] && (u inside {8'h41, 8'h43, 8'h47, 8'h54, 8'h4E})) hit = 1'b1;
      // A C G U N
      if (cls[CLS_RNA] && (u inside {8'h41, 8'h43, 8'h47, 8'h55, 8'h4E})) hit = 1'b1;
      // R Y K M S W B D H V
      if (cls[CLS_AMBIG] && (u inside {8'h52, 8'h59, 8'h4B, 8'h4D, 8'h53,
                                       8'h57, 8'h42, 8'h44, 8'h48, 8'h56})) hit = 1'b1;
      // X
      if (cls[CLS_MASK] && u == 8'h58) hit = 1'b1;
      base_ok = case_ok && hit;
    end
  endfunction

  // Check a quality byte against the encoding's range
  function automatic logic quality_ok(input logic [7:0] c, input logic [1:0] enc);
    logic [7:0] lo;
    begin
      case (enc)
        ENC_SOLEXA:   lo = Q_LOW_SOLEXA;
        ENC_ILLUMINA: lo = Q_LOW_ILLUMINA;
        default:      lo = Q_LOW_STD;
      endcase
      quality_ok = (c >= lo) && (c <= Q_HIGH);
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/fastq_record_parser.sv */
// ----------------------------------------------------------------------------
// fastq_record_parser
// Byte-wide FASTQ record parser with field tagging and validity checks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one text byte per transfer, or
//   a stream-end marker that closes the stream and restarts the parser.
//   Output channel (out_valid/out_ready) carries events: record start, field
//   byte, field end, record end, error and complete. One input byte causes
//   zero to three events; out_last flags the final event of each byte.
//   Events of a byte are presented in the cycle after its transfer.
//   Plain field bytes stream at one per cycle while out_ready is high; a byte
//   with more events holds off the next byte until the three-entry result
//   buffer is down to its last entry and that entry leaves.
//   A byte with no event (blank line, halted parser) leaves the buffer empty.
//   A stalled receiver holds the buffer and, through in_ready, the input.
//   Reset clears the buffer, returns the parser to the start phase with the
//   line number at one, and loads register defaults. Registers are written
//   through cfg_we/cfg_index/cfg_data by the user only while the parser is
//   idle (not enforced); a first_mate write also loads the current mate bit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fastq_record_parser_macros.svh"

module fastq_record_parser #(
  parameter int COUNT_BITS = fqp_pkg::COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [5:0]  cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_stream_end,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_event_res,
  output logic [1:0]       out_field_kind,
  output logic [7:0]       out_data_byte,
  output logic [2:0]       out_error_code,
  output logic [31:0]      out_line_no,
  output logic             out_mate,
  output logic             out_last
);

  localparam int EXT_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  // configuration registers
  logic [5:0] cls_r;
  logic [1:0] enc_r;
  logic       interleave_r;
  logic       first_mate_r;

  // parser state
  fqp_pkg::phase_t        phase_r, phase_nxt;
  logic [COUNT_BITS-1:0]  line_r, line_nxt;
  logic [COUNT_BITS-1:0]  bases_r, bases_nxt;
  logic [COUNT_BITS-1:0]  quals_r, quals_nxt;
  logic                   mate_r, mate_nxt;

  // result buffer
  fqp_pkg::res_t          slot_r [3];
  fqp_pkg::res_t          slot_nxt [3];
  logic [1:0]             cnt_r, n_nxt;
  logic [31:0]            line_o_r, line_o_nxt;
  logic                   mate_o_r;

  logic                   in_fire;
  logic                   out_fire;
  logic                   is_nl;
  logic                   is_plus;
  logic                   seq_path;
  logic [COUNT_BITS-1:0]  line_inc;
  logic [COUNT_BITS-1:0]  bases_inc;
  logic [COUNT_BITS-1:0]  quals_inc;
  logic [COUNT_BITS-1:0]  line_src;
  logic [EXT_W-1:0]       line_ext;

  // handshakes: take a byte only when the buffer is empty or its last entry leaves now
  assign in_ready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_fire  = out_valid && out_ready;

  // drive outputs from the buffer head
  assign out_event_res   = slot_r[0].ev;
  assign out_field_kind  = slot_r[0].kind;
  assign out_data_byte   = slot_r[0].data;
  assign out_error_code  = slot_r[0].err;
  assign out_line_no     = line_o_r;
  assign out_mate        = mate_o_r;
  assign out_last        = (cnt_r == 2'd1);

  // saturating increments
  assign line_inc  = (line_r == '1)  ? line_r  : line_r + COUNT_BITS'(1);
  assign bases_inc = (bases_r == '1) ? bases_r : bases_r + COUNT_BITS'(1);
  assign quals_inc = (quals_r == '1) ? quals_r : quals_r + COUNT_BITS'(1);

  assign is_nl    = (in_text_byte == fqp_pkg::CH_NL);
  assign is_plus  = (in_text_byte == fqp_pkg::CH_PLUS);
  assign seq_path = (phase_r == fqp_pkg::PH_SEQ) ||
                    (phase_r == fqp_pkg::PH_SEQNL && !is_plus);

  // clip the reported line number to 32 bits
  assign line_src   = in_stream_end ? line_r : line_nxt;
  assign line_ext   = EXT_W'(line_src);
  assign line_o_nxt = (line_ext > EXT_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : line_ext[31:0];

  // parse one byte: next state and its events
  always_comb begin
    phase_nxt = phase_r;
    line_nxt  = line_r;
    bases_nxt = bases_r;
    quals_nxt = quals_r;
    mate_nxt  = mate_r;
    n_nxt     = 2'd0;
    for (int i = 0; i < 3; i++) begin
      slot_nxt[i] = '{ev: fqp_pkg::EV_REC_START, kind: fqp_pkg::FK_HEADER1,
                      data: in_text_byte, err: fqp_pkg::ERR_NONE};
    end

    if (in_stream_end) begin
      // close any open record, then report completion and restart
      for (int i = 0; i < 3; i++) slot_nxt[i].data = 8'd0;
      if (phase_r != fqp_pkg::PH_START && phase_r != fqp_pkg::PH_HALT) begin
        slot_nxt[0].ev  = fqp_pkg::EV_ERROR;
        slot_nxt[0].err = fqp_pkg::ERR_INCOMPLETE;
        slot_nxt[1].ev  = fqp_pkg::EV_COMPLETE;
        n_nxt           = 2'd2;
      end else begin
        slot_nxt[0].ev = fqp_pkg::EV_COMPLETE;
        n_nxt          = 2'd1;
      end
      phase_nxt = fqp_pkg::PH_START;
      line_nxt  = COUNT_BITS'(1);
      bases_nxt = '0;
      quals_nxt = '0;
      mate_nxt  = first_mate_r;
    end else if (phase_r != fqp_pkg::PH_HALT) begin
      if (is_nl) line_nxt = line_inc;

      if (phase_r == fqp_pkg::PH_SEQNL && is_plus) begin
        // plus line closes the sequence field
        slot_nxt[0].ev   = fqp_pkg::EV_FIELD_END;
        slot_nxt[0].kind = fqp_pkg::FK_SEQ;
        n_nxt            = 2'd1;
        phase_nxt        = fqp_pkg::PH_HEAD2;
      end else if (seq_path) begin
        // sequence line byte
        if (is_nl) begin
          phase_nxt = fqp_pkg::PH_SEQNL;
        end else if (!fqp_pkg::base_ok(in_text_byte, cls_r)) begin
          slot_nxt[0].ev  = fqp_pkg::EV_ERROR;
          slot_nxt[0].err = fqp_pkg::ERR_BAD_BASE;
          n_nxt           = 2'd1;
          phase_nxt       = fqp_pkg::PH_HALT;
        end else begin
          slot_nxt[0].ev   = fqp_pkg::EV_FIELD_BYTE;
          slot_nxt[0].kind = fqp_pkg::FK_SEQ;
          n_nxt            = 2'd1;
          phase_nxt        = (phase_r == fqp_pkg::PH_SEQNL) ? fqp_pkg::PH_SEQ : phase_r;
          bases_nxt        = bases_inc;
        end
      end else begin
        case (phase_r)
          fqp_pkg::PH_START: begin
            if (in_text_byte == fqp_pkg::CH_AT) begin
              n_nxt     = 2'd1;
              phase_nxt = fqp_pkg::PH_HEAD1;
            end else if (!is_nl) begin
              slot_nxt[0].ev  = fqp_pkg::EV_ERROR;
              slot_nxt[0].err = fqp_pkg::ERR_NO_HEADER;
              n_nxt           = 2'd1;
              phase_nxt       = fqp_pkg::PH_HALT;
            end
          end
          fqp_pkg::PH_HEAD1: begin
            n_nxt = 2'd1;
            if (is_nl) begin
              slot_nxt[0].ev = fqp_pkg::EV_FIELD_END;
              phase_nxt      = fqp_pkg::PH_SEQ;
              bases_nxt      = '0;
            end else begin
              slot_nxt[0].ev = fqp_pkg::EV_FIELD_BYTE;
            end
          end
          fqp_pkg::PH_HEAD2: begin
            n_nxt            = 2'd1;
            slot_nxt[0].kind = fqp_pkg::FK_HEADER2;
            if (is_nl) begin
              slot_nxt[0].ev = fqp_pkg::EV_FIELD_END;
              phase_nxt      = fqp_pkg::PH_QUAL;
              quals_nxt      = '0;
            end else begin
              slot_nxt[0].ev = fqp_pkg::EV_FIELD_BYTE;
            end
          end
          fqp_pkg::PH_QUAL: begin
            if (!is_nl && !fqp_pkg::quality_ok(in_text_byte, enc_r)) begin
              slot_nxt[0].ev  = fqp_pkg::EV_ERROR;
              slot_nxt[0].err = fqp_pkg::ERR_BAD_QUAL;
              n_nxt           = 2'd1;
              phase_nxt       = fqp_pkg::PH_HALT;
            end else begin
              if (!is_nl) begin
                slot_nxt[0].ev   = fqp_pkg::EV_FIELD_BYTE;
                slot_nxt[0].kind = fqp_pkg::FK_QUAL;
                n_nxt            = 2'd1;
                quals_nxt        = quals_inc;
              end
              // close the record once qualities match bases
              if (quals_nxt == bases_r) begin
                if (is_nl) begin
                  slot_nxt[0].ev   = fqp_pkg::EV_FIELD_END;
                  slot_nxt[0].kind = fqp_pkg::FK_QUAL;
                  slot_nxt[1].ev   = fqp_pkg::EV_REC_END;
                  n_nxt            = 2'd2;
                end else begin
                  slot_nxt[1].ev   = fqp_pkg::EV_FIELD_END;
                  slot_nxt[1].kind = fqp_pkg::FK_QUAL;
                  slot_nxt[2].ev   = fqp_pkg::EV_REC_END;
                  n_nxt            = 2'd3;
                end
                phase_nxt = fqp_pkg::PH_START;
                if (interleave_r) mate_nxt = !mate_r;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // configuration registers and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r        <= 6'd49;
      enc_r        <= 2'd1;
      interleave_r <= 1'b0;
      first_mate_r <= 1'b0;
      phase_r      <= fqp_pkg::PH_START;
      line_r       <= COUNT_BITS'(1);
      bases_r      <= '0;
      quals_r      <= '0;
      mate_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fqp_pkg::REG_SEQ_CLASSES: cls_r        <= cfg_data;
        fqp_pkg::REG_QUAL_ENC:    enc_r        <= cfg_data[1:0];
        fqp_pkg::REG_INTERLEAVE:  interleave_r <= cfg_data[0];
        fqp_pkg::REG_FIRST_MATE: begin
          first_mate_r <= cfg_data[0];
          mate_r       <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      line_r  <= line_nxt;
      bases_r <= bases_nxt;
      quals_r <= quals_nxt;
      mate_r  <= mate_nxt;
    end
  end

  // result buffer count: load on transfer in, advance on transfer out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (in_fire) begin
      cnt_r <= n_nxt;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot_r   <= slot_nxt;
      line_o_r <= line_o_nxt;
      mate_o_r <= mate_r;
    end else if (out_fire) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

  // checks
  `FQP_ASSERT_NOW(a_no_overwrite, in_ready && cnt_r != 2'd0, out_ready && cnt_r == 2'd1, "byte taken over pending events")
  `FQP_ASSERT_NEXT(a_restart, in_fire && in_stream_end && !cfg_we, phase_r == fqp_pkg::PH_START && line_r == COUNT_BITS'(1), "stream end did not restart parser")
  `FQP_ASSERT_NEXT(a_halt_silent, in_fire && !in_stream_end && phase_r == fqp_pkg::PH_HALT, cnt_r == 2'd0 && phase_r == fqp_pkg::PH_HALT, "halted parser produced events")
  `FQP_ASSERT_NOW(a_complete_last, out_valid && slot_r[0].ev == fqp_pkg::EV_COMPLETE, cnt_r == 2'd1, "complete event is not the final event")

endmodule

`default_nettype wire
